/* design/rme_pkg.sv */
// Package for the rotation matrix to Euler angle converter.
// Holds the datapath word type, the CORDIC vector types, the arctangent table and the
// CORDIC step functions. It depends on nothing else.
package rme_pkg;

    localparam int W = 34;
    localparam int IN_W = 16;
    localparam int OUT_W = 16;
    localparam int WORK_SHIFT = 12;
    localparam int INT_FRAC = 30;
    localparam int MAG_W = 30;

    typedef logic signed [W-1:0] wd_t;

    localparam wd_t PI_Q30 = wd_t'(64'sd3373259426);
    localparam wd_t HALF_PI_Q30 = wd_t'(64'sd1686629713);
    localparam logic [MAG_W-1:0] INV_GAIN_Q30 = MAG_W'(652032874);

    // One vector under vectoring, with its accumulated angle.
    typedef struct packed {
        wd_t x;
        wd_t y;
        wd_t ang;
        logic zero;
    } vec_t;

    // Two column vectors that follow the yaw micro-rotations.
    typedef struct packed {
        wd_t a0;
        wd_t b0;
        wd_t a1;
        wd_t b1;
    } col_t;

    function automatic wd_t atan_q30(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0: v = 32'h3243F6A8;
            5'd1: v = 32'h1DAC6705;
            5'd2: v = 32'h0FADBAFC;
            5'd3: v = 32'h07F56EA6;
            5'd4: v = 32'h03FEAB76;
            5'd5: v = 32'h01FFD55B;
            5'd6: v = 32'h00FFFAAA;
            5'd7: v = 32'h007FFF55;
            5'd8: v = 32'h003FFFEA;
            5'd9: v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return wd_t'(v);
    endfunction

    // Sets up a vector for vectoring: if x < 0, a quarter turn puts it in the right half plane.
    function automatic vec_t vec_start(input wd_t x, input wd_t y);
        vec_t v;
        v.zero = (x == '0) && (y == '0);
        v.x = x;
        v.y = y;
        v.ang = '0;
        if (x[W-1])
        begin
            if (!y[W-1])
            begin
                v.x = y;
                v.y = -x;
                v.ang = HALF_PI_Q30;
            end
            else
            begin
                v.x = -y;
                v.y = x;
                v.ang = -HALF_PI_Q30;
            end
        end
        return v;
    endfunction

    // Columns get the same quarter turn as the vector (x, y).
    function automatic col_t col_start(input wd_t x, input wd_t y, input col_t c);
        col_t r;
        r = c;
        if (x[W-1])
        begin
            if (!y[W-1])
            begin
                r.a0 = c.b0;
                r.b0 = -c.a0;
                r.a1 = c.b1;
                r.b1 = -c.a1;
            end
            else
            begin
                r.a0 = -c.b0;
                r.b0 = c.a0;
                r.a1 = -c.b1;
                r.b1 = c.a1;
            end
        end
        return r;
    endfunction

    function automatic vec_t vec_iter(input vec_t v, input logic [4:0] sh);
        vec_t r;
        wd_t xs;
        wd_t ys;
        r = v;
        xs = v.x >>> sh;
        ys = v.y >>> sh;
        if (!v.zero)
        begin
            if (!v.y[W-1])
            begin
                r.x = v.x + ys;
                r.y = v.y - xs;
                r.ang = v.ang + atan_q30(sh);
            end
            else
            begin
                r.x = v.x - ys;
                r.y = v.y + xs;
                r.ang = v.ang - atan_q30(sh);
            end
        end
        return r;
    endfunction

    // The direction comes from the yaw vector before its step.
    function automatic col_t col_iter(input col_t c, input logic down, input logic hold,
                                      input logic [4:0] sh);
        col_t r;
        r = c;
        if (!hold)
        begin
            if (down)
            begin
                r.a0 = c.a0 + (c.b0 >>> sh);
                r.b0 = c.b0 - (c.a0 >>> sh);
                r.a1 = c.a1 + (c.b1 >>> sh);
                r.b1 = c.b1 - (c.a1 >>> sh);
            end
            else
            begin
                r.a0 = c.a0 - (c.b0 >>> sh);
                r.b0 = c.b0 + (c.a0 >>> sh);
                r.a1 = c.a1 - (c.b1 >>> sh);
                r.b1 = c.b1 + (c.a1 >>> sh);
            end
        end
        return r;
    endfunction

endpackage

/* design/rotation_matrix_to_euler.sv */
// Top level of the rotation matrix to Z-Y-X Euler angle converter.
// A pipeline of three vectoring CORDICs and one constant multiply; uses rme_pkg.
//
// Usage:
// A matrix arrives as one transfer on the slave stream (s_tvalid, s_tready, s_tdata) and
// the angle triple leaves as one transfer on the master stream (m_tvalid, m_tready, m_tdata).
// Yaw is found first by a vectoring CORDIC that also turns two matrix columns by -yaw.
// The yaw magnitude is scaled by 1/K in one multiply stage, and then pitch and roll run
// side by side through two more vectoring CORDICs. Each angle is wrapped to [-pi, pi) and
// rounded in the output register.
// The latency is set by the two CORDIC chains, the multiply stage and the output register in
// series; a chain is a start register and one register per micro-rotation. Throughput is one
// matrix per cycle when not stalled. All stages advance together whenever the output register
// is empty or its transfer is taken; when the receiver stalls with a result waiting, the
// whole pipeline holds and s_tready drops, so nothing is lost or repeated.
// Reset clears every valid bit; the data registers are not reset. No item is in flight
// after reset and s_tready is high at once.
module rotation_matrix_to_euler #(
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int CORDIC_STAGES = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // Fields from bit 0 up: r00, r01, r02, r10, r11, r12, r20, 16 bits each.
    input  logic [7*rme_pkg::IN_W-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // Fields from bit 0 up: yaw_angle, pitch_angle, roll_angle, 16 bits each.
    output logic [3*rme_pkg::OUT_W-1:0] m_tdata
);
    import rme_pkg::*;

    localparam int N = CORDIC_STAGES;
    localparam int SH = INT_FRAC - ANGLE_FRAC_BITS;
    localparam wd_t HALF = wd_t'(1) <<< (SH - 1);
    localparam wd_t PI_OUT = (PI_Q30 + HALF) >>> SH;

    // Wrap a Q30 angle to [-pi, pi) and round half up to the output format.
    function automatic logic [OUT_W-1:0] angle_out(input wd_t a);
        wd_t w;
        wd_t r;
        w = a;
        if (w >= PI_Q30)
        begin
            w = w - (PI_Q30 <<< 1);
        end
        if (w < -PI_Q30)
        begin
            w = w + (PI_Q30 <<< 1);
        end
        r = (w + HALF) >>> SH;
        if (r >= PI_OUT)
        begin
            r = r - (PI_OUT <<< 1);
        end
        return r[OUT_W-1:0];
    endfunction

    function automatic wd_t scale_in(input logic [IN_W-1:0] v);
        return wd_t'(signed'(v)) <<< WORK_SHIFT;
    endfunction

    logic en;

    // Yaw chain: the vector, the two columns and r20 ride along.
    vec_t ya_reg [0:N];
    col_t yc_reg [0:N];
    wd_t yr20_reg [0:N];
    logic y_vld_reg [0:N];

    // Multiply stage.
    logic [2*MAG_W-1:0] prod_reg;
    wd_t m_yaw_reg;
    wd_t m_r20_reg;
    wd_t m_rx_reg;
    wd_t m_ry_reg;
    logic m_vld_reg;

    // Pitch and roll chains.
    vec_t pa_reg [0:N];
    vec_t ra_reg [0:N];
    wd_t pyaw_reg [0:N];
    logic p_vld_reg [0:N];

    logic out_vld_reg;
    logic [3*OUT_W-1:0] out_data_reg;

    wd_t in_x;
    wd_t in_y;
    col_t in_col;
    wd_t hyp;

    assign en = !out_vld_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_vld_reg;
    assign m_tdata = out_data_reg;

    always_comb
    begin
        in_x = scale_in(s_tdata[0*IN_W +: IN_W]);
        in_y = scale_in(s_tdata[3*IN_W +: IN_W]);
        in_col.a0 = scale_in(s_tdata[1*IN_W +: IN_W]);
        in_col.b0 = scale_in(s_tdata[4*IN_W +: IN_W]);
        in_col.a1 = scale_in(s_tdata[2*IN_W +: IN_W]);
        in_col.b1 = scale_in(s_tdata[5*IN_W +: IN_W]);
        hyp = wd_t'(prod_reg >> INT_FRAC);
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= N; k++)
            begin
                y_vld_reg[k] <= 1'b0;
                p_vld_reg[k] <= 1'b0;
            end
            m_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            y_vld_reg[0] <= s_tvalid;
            for (int k = 1; k <= N; k++)
            begin
                y_vld_reg[k] <= y_vld_reg[k-1];
                p_vld_reg[k] <= p_vld_reg[k-1];
            end
            m_vld_reg <= y_vld_reg[N];
            p_vld_reg[0] <= m_vld_reg;
            out_vld_reg <= p_vld_reg[N];
        end
    end

    // Data path. Each CORDIC stage after the start register is one micro-rotation.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ya_reg[0] <= vec_start(in_x, in_y);
            yc_reg[0] <= col_start(in_x, in_y, in_col);
            yr20_reg[0] <= scale_in(s_tdata[6*IN_W +: IN_W]);
            for (int k = 0; k < N; k++)
            begin
                ya_reg[k+1] <= vec_iter(ya_reg[k], 5'(k));
                yc_reg[k+1] <= col_iter(yc_reg[k], !ya_reg[k].y[W-1], ya_reg[k].zero, 5'(k));
                yr20_reg[k+1] <= yr20_reg[k];
            end

            prod_reg <= (2*MAG_W)'(ya_reg[N].x[MAG_W-1:0]) * (2*MAG_W)'(INV_GAIN_Q30);
            m_yaw_reg <= ya_reg[N].ang;
            m_r20_reg <= -yr20_reg[N];
            m_rx_reg <= yc_reg[N].b0;
            m_ry_reg <= -yc_reg[N].b1;

            pa_reg[0] <= vec_start(hyp, m_r20_reg);
            ra_reg[0] <= vec_start(m_rx_reg, m_ry_reg);
            pyaw_reg[0] <= m_yaw_reg;
            for (int k = 0; k < N; k++)
            begin
                pa_reg[k+1] <= vec_iter(pa_reg[k], 5'(k));
                ra_reg[k+1] <= vec_iter(ra_reg[k], 5'(k));
                pyaw_reg[k+1] <= pyaw_reg[k];
            end

            out_data_reg <= {angle_out(ra_reg[N].ang), angle_out(pa_reg[N].ang),
                             angle_out(pyaw_reg[N])};
        end
    end

    // A zero vector keeps a zero angle through the whole yaw chain.
    a_zero_yaw: assert property (@(posedge clk) disable iff (!rst_n)
        ya_reg[N].zero |-> ya_reg[N].ang == '0)
        else $error("zero vector left the yaw chain with a nonzero angle");

    // The yaw result is wrapped into [-pi, pi).
    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[OUT_W-1:0]) >= -$signed(PI_OUT[OUT_W-1:0]))
                  && ($signed(m_tdata[OUT_W-1:0]) < $signed(PI_OUT[OUT_W-1:0])))
        else $error("yaw outside the wrapped range");

    // An item leaving the last pitch stage reaches the output register when it advances.
    a_pipe_move: assert property (@(posedge clk) disable iff (!rst_n)
        en && p_vld_reg[N] |=> out_vld_reg)
        else $error("item lost between pipeline and output register");

endmodule
